### hdl/cma_pkg.sv
package cma_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned RadiusW   = 5;
  localparam int unsigned MaxRadius = 31;
  localparam int unsigned Depth     = 64;
  localparam int unsigned PtrW      = $clog2(Depth);
  localparam int unsigned SeenW     = 6;
  localparam int unsigned SumW      = 22;
  localparam int unsigned AvgW      = 17;
  localparam int unsigned OutDataW  = ((AvgW + 7) / 8) * 8;
  localparam int unsigned DivCntW   = $clog2(SumW);

  // Result value for a position without a full window.
  localparam logic [AvgW-1:0] AvgNone = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // capture the input transfer, start the delay-line read
    logic update;     // fold the sample into the window, start the divide
    logic out_load;   // load the output register
    logic out_none;   // load the no-window marker instead of the quotient
    logic out_last;   // mark the loaded result as the last of its run
    logic flush_dec;  // count down one flush result
  } cma_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pre_none;   // a no-window result comes before the average
    logic do_avg;     // an average is due for this sample
    logic rest_zero;  // no flush results left
    logic rest_one;   // exactly one flush result left
    logic div_done;   // quotient ready
  } cma_status_t;

endpackage

### hdl/centered_moving_average.sv
// Channel     | Direction | Transfer when             | Payload
// ------------+-----------+---------------------------+-------------------------------------
// s_axis      | in        | s_axis_tvalid&tready      | tdata: sample; tlast: last_sample
// m_axis      | out       | m_axis_tvalid&tready      | tdata: average; tlast: last_of_run
// cfg         | in        | cfg_valid_i&cfg_ready_o   | cfg_data_i: window_radius
//
// One sample at a time: the sequencer reads the outgoing sample, updates the window,
// then loads each result once the output slot is free; an average waits on the
// bit-serial divider, which starts at the update, and a warm-up sample may have no result.
// A last sample then adds its flush results, one per free output slot.
// Reset leaves radius 1 and an empty stream; the delay line needs no clearing.
// A stalled output holds its result and the sequencer waits for the slot.
module centered_moving_average (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [cma_pkg::SampleW-1:0]  s_axis_tdata,  // [15:0] sample
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [cma_pkg::OutDataW-1:0] m_axis_tdata,  // [16:0] average, rest zero
  output logic                         m_axis_tlast,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [cma_pkg::RadiusW-1:0]  cfg_data_i
);
  import cma_pkg::*;

  cma_cmd_t    cmd;
  cma_status_t status;
  logic [AvgW-1:0] average;
  logic        cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  cma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cma_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_radius_i  (cfg_data_i),
    .sample_i      (s_axis_tdata),
    .last_sample_i (s_axis_tlast),
    .cmd_i         (cmd),
    .status_o      (status),
    .average_o     (average),
    .last_of_run_o (m_axis_tlast)
  );

  assign m_axis_tdata = OutDataW'(average);

  // A result is loaded only into a free output slot.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten");

  // An average is loaded only once the divider is done.
  a_avg_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_load && !cmd.out_none) |-> status.div_done)
    else $error("average loaded before divide finished");

  // An average never sets the sign bit.
  a_avg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_load && !cmd.out_none) |=> !m_axis_tdata[AvgW-1])
    else $error("average out of range");

  // One sample at a time: no second transfer right after the first.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while busy");

endmodule

### hdl/cma_ram.sv
module cma_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/cma_div.sv
module cma_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [cma_pkg::SumW-1:0]  dividend_i,
  input  logic [cma_pkg::SeenW-1:0] divisor_i,
  output logic [cma_pkg::SumW-1:0]  quotient_o,
  output logic                      done_o
);
  import cma_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [SeenW-1:0]   rem_q, rem_d;
  logic [SumW-1:0]    quo_q, quo_d;
  logic [SeenW-1:0]   dvs_q, dvs_d;
  logic [SeenW:0]     trial;
  logic [SeenW:0]     diff;
  logic               fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign trial = {rem_q, quo_q[SumW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = DivCntW'(SumW - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[SeenW-1:0] : trial[SeenW-1:0];
      quo_d = {quo_q[SumW-2:0], fits};
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state under reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

### hdl/cma_dp.sv
module cma_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cma_pkg::RadiusW-1:0] cfg_radius_i,
  input  logic [cma_pkg::SampleW-1:0] sample_i,
  input  logic                        last_sample_i,
  input  cma_pkg::cma_cmd_t           cmd_i,
  output cma_pkg::cma_status_t        status_o,
  output logic [cma_pkg::AvgW-1:0]    average_o,
  output logic                        last_of_run_o
);
  import cma_pkg::*;

  logic [RadiusW-1:0] radius_q;
  logic [SampleW-1:0] sample_q;
  logic               last_q;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [PtrW-1:0]    wp_q, wp_d;
  logic [SeenW-1:0]   seen_q, seen_d;
  logic [RadiusW-1:0] rest_q, rest_d;
  logic               pre_none_q, do_avg_q;
  logic [AvgW-1:0]    avg_q;
  logic               out_last_q;

  logic [SeenW-1:0]   win;
  logic [SeenW-1:0]   k_ext;
  logic               full;
  logic [SeenW-1:0]   seen_nx;
  logic [SumW-1:0]    sum_nx;
  logic               pre_none_nx;
  logic               do_avg_nx;
  logic [RadiusW-1:0] rest_nx;
  logic [SeenW-1:0]   over_k;
  logic [SampleW-1:0] old_sample;
  logic [PtrW-1:0]    old_addr;
  logic [SumW-1:0]    quotient;
  logic               div_done;

  // Window size 2k+1 and the delay-line slot that leaves the window.
  assign k_ext    = SeenW'(radius_q);
  assign win      = {radius_q, 1'b1};
  assign old_addr = wp_q - PtrW'(win);

  // Decode the step once the outgoing sample is read.
  assign full        = seen_q >= win;
  assign pre_none_nx = !full && (seen_q < k_ext);
  assign seen_nx     = full ? win : seen_q + SeenW'(1);
  assign sum_nx      = full ? sum_q - SumW'(old_sample) + SumW'(sample_q)
                            : sum_q + SumW'(sample_q);
  assign do_avg_nx   = seen_nx == win;
  assign over_k      = seen_nx - k_ext;

  always_comb begin
    rest_nx = '0;
    if (last_q) begin
      if (seen_nx >= win) begin
        rest_nx = radius_q;
      end else if (seen_nx > k_ext) begin
        rest_nx = over_k[RadiusW-1:0];
      end
    end
  end

  // Stream state: a radius write or a last sample starts a new stream.
  always_comb begin
    sum_d  = sum_q;
    wp_d   = wp_q;
    seen_d = seen_q;
    rest_d = rest_q;
    if (cfg_we_i) begin
      sum_d  = '0;
      wp_d   = '0;
      seen_d = '0;
    end else if (cmd_i.update) begin
      sum_d  = last_q ? '0 : sum_nx;
      wp_d   = last_q ? '0 : wp_q + PtrW'(1);
      seen_d = last_q ? '0 : seen_nx;
      rest_d = rest_nx;
    end else if (cmd_i.flush_dec) begin
      rest_d = rest_q - RadiusW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= RadiusW'(1);
      sum_q      <= '0;
      wp_q       <= '0;
      seen_q     <= '0;
      rest_q     <= '0;
      pre_none_q <= 1'b0;
      do_avg_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        radius_q <= cfg_radius_i;
      end
      sum_q  <= sum_d;
      wp_q   <= wp_d;
      seen_q <= seen_d;
      rest_q <= rest_d;
      if (cmd_i.update) begin
        pre_none_q <= pre_none_nx;
        do_avg_q   <= do_avg_nx;
      end
    end
  end

  // Capture the input transfer and the output result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= sample_i;
      last_q   <= last_sample_i;
    end
    if (cmd_i.out_load) begin
      avg_q      <= cmd_i.out_none ? AvgNone : quotient[AvgW-1:0];
      out_last_q <= cmd_i.out_last;
    end
  end

  cma_ram #(
    .Width (SampleW),
    .Depth (Depth)
  ) u_delay (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (wp_q),
    .wdata_i (sample_q),
    .re_i    (cmd_i.accept),
    .raddr_i (old_addr),
    .rdata_o (old_sample)
  );

  cma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.update),
    .dividend_i (sum_nx),
    .divisor_i  (win),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  assign status_o.pre_none  = pre_none_q;
  assign status_o.do_avg    = do_avg_q;
  assign status_o.rest_zero = rest_q == '0;
  assign status_o.rest_one  = rest_q == RadiusW'(1);
  assign status_o.div_done  = div_done;

  assign average_o     = avg_q;
  assign last_of_run_o = out_last_q;

endmodule

### hdl/cma_ctrl.sv
module cma_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  cma_pkg::cma_status_t status_i,
  output cma_pkg::cma_cmd_t    cmd_o
);
  import cma_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StPre,
    StAvg,
    StFlush
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Sequence one sample: read, update, then its results in order.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StRead;
        end
      end
      StRead: begin
        cmd_o.update = 1'b1;
        state_d      = StPre;
      end
      StPre: begin
        if (!status_i.pre_none) begin
          state_d = StAvg;
        end else if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_none = 1'b1;
          cmd_o.out_last = !status_i.do_avg && status_i.rest_zero;
          state_d        = StAvg;
        end
      end
      StAvg: begin
        if (!status_i.do_avg) begin
          state_d = StFlush;
        end else if (status_i.div_done && out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = status_i.rest_zero;
          state_d        = StFlush;
        end
      end
      StFlush: begin
        if (status_i.rest_zero) begin
          state_d = StIdle;
        end else if (out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_none  = 1'b1;
          cmd_o.out_last  = status_i.rest_one;
          cmd_o.flush_dec = 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Output register valid: set on load, drop on transfer.
  assign out_valid_d = cmd_o.out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == StIdle;
  assign out_valid_o = out_valid_q;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cma_pkg::*;

  localparam int unsigned RandomItems  = 500;
  localparam int unsigned SettleCycles = 64;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned MaxErrShown  = 10;

  typedef struct {
    logic [SampleW-1:0] sample;
    logic               is_last;
  } sample_item_t;

  typedef struct {
    logic [AvgW-1:0] avg;
    logic            last;
  } avg_result_t;

  // DUT signals; the inputs are known from time zero
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [SampleW-1:0]  s_axis_tdata  = '0;  // [15:0] sample
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // [16:0] average, rest zero
  logic                m_axis_tlast;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [RadiusW-1:0]  cfg_data_i    = '0;

  // Stimulus and expected-result stores
  sample_item_t pending_samples[$];
  avg_result_t  exp_results[$];

  // Window tracking state
  logic [SampleW-1:0] dly_line[Depth];
  logic [SumW-1:0]    win_sum    = '0;
  logic [PtrW-1:0]    wr_ptr     = '0;
  logic [SeenW-1:0]   n_seen     = '0;
  logic [RadiusW-1:0] radius_reg = RadiusW'(1);

  // Run bookkeeping
  int unsigned n_queued  = 0;
  int unsigned n_in      = 0;
  int unsigned n_out     = 0;
  int unsigned n_avg     = 0;
  int unsigned n_none    = 0;
  int unsigned n_cfg     = 0;
  int unsigned n_maxr    = 0;
  int unsigned err_count = 0;
  logic        in_xfer   = 1'b0;
  logic        hold_req  = 1'b0;
  logic        did_hold  = 1'b0;

  // Driver and receiver pacing
  int unsigned  burst_left = 0;
  int unsigned  gap_left   = 0;
  int unsigned  rx_cyc     = 0;
  int unsigned  rx_mode    = 0;
  sample_item_t cur_item;

  centered_moving_average dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= MaxErrShown) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Fold one sample into the window and queue the results it releases
  task automatic fold_sample(input logic [SampleW-1:0] smp, input logic is_last);
    int unsigned       k;
    int unsigned       w;
    int unsigned       rest;
    logic [PtrW-1:0]   old_idx;
    avg_result_t       step_q[$];
    avg_result_t       r;
    k = radius_reg;
    if (k > MaxRadius) k = MaxRadius;
    if (k > (Depth - 2) / 2) k = (Depth - 2) / 2;
    w = 2 * k + 1;
    r.last = 1'b0;
    if (n_seen >= w) begin
      // full window: slide out the oldest sample
      old_idx = PtrW'(wr_ptr + Depth - w);
      win_sum = win_sum - SumW'(dly_line[old_idx]) + SumW'(smp);
      n_seen  = SeenW'(w);
      r.avg   = AvgW'(win_sum / w);
      step_q.insert(step_q.size(), r);
    end else begin
      // warm-up: leading positions get the no-window mark
      if (n_seen < k) begin
        r.avg = AvgNone;
        step_q.insert(step_q.size(), r);
      end
      win_sum = win_sum + SumW'(smp);
      n_seen  = n_seen + 1'b1;
      if (n_seen == w) begin
        r.avg = AvgW'(win_sum / w);
        step_q.insert(step_q.size(), r);
      end
    end
    dly_line[wr_ptr] = smp;
    wr_ptr = wr_ptr + 1'b1;
    // end of stream: mark the trailing positions and start over
    if (is_last) begin
      rest = (n_seen >= w) ? k : ((n_seen > k) ? n_seen - k : 0);
      repeat (rest) begin
        r.avg = AvgNone;
        step_q.insert(step_q.size(), r);
      end
      win_sum = '0;
      n_seen  = '0;
      wr_ptr  = '0;
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) exp_results.insert(exp_results.size(), step_q[i]);
  endtask

  task automatic add_item(input logic [SampleW-1:0] smp, input logic is_last);
    sample_item_t it;
    it.sample  = smp;
    it.is_last = is_last;
    pending_samples.insert(pending_samples.size(), it);
    n_queued++;
  endtask

  // Wait until every sample is in and every result is out, then let the block settle
  task automatic drain();
    while (n_in != n_queued || exp_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_radius(input logic [RadiusW-1:0] val);
    int unsigned seen_writes;
    seen_writes = n_cfg;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(negedge clk_i); while (n_cfg == seen_writes);
    cfg_valid_i <= 1'b0;
  endtask

  // Sender: bursts of random length with random gaps between them
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_xfer) begin
      if (gap_left > 0 || pending_samples.size() == 0) begin
        if (gap_left > 0) gap_left--;
        s_axis_tvalid <= 1'b0;
      end else begin
        cur_item = pending_samples.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cur_item.sample;
        s_axis_tlast  <= cur_item.is_last;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Receiver: the stall pattern is redrawn periodically from four modes; hold_req forces a long stall
  always @(negedge clk_i) begin
    rx_cyc++;
    if (rx_cyc % 50 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_req) begin
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= ($urandom_range(0, 7) != 0);
        default: m_axis_tready <= rx_cyc[2];
      endcase
    end
  end

  // Hold off the output once the sender has plenty queued, so the input backs up
  initial begin
    do @(posedge clk_i); while (!(n_in >= 120 && pending_samples.size() > 20));
    hold_req = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_req = 1'b0;
    did_hold = 1'b1;
  end

  // Monitor: check results first, then predict from accepted samples and writes
  always @(posedge clk_i) begin
    avg_result_t want;
    in_xfer <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (exp_results.size() == 0) begin
          note_error($sformatf("unexpected result tdata=%h tlast=%b",
                               m_axis_tdata, m_axis_tlast));
        end else begin
          want = exp_results.pop_front();
          n_out++;
          if (want.avg == AvgNone) n_none++;
          else n_avg++;
          if (m_axis_tdata !== {{(OutDataW - AvgW){1'b0}}, want.avg})
            note_error($sformatf("result %0d average: expected %h, got %h",
                                 n_out, want.avg, m_axis_tdata));
          if (m_axis_tlast !== want.last)
            note_error($sformatf("result %0d last_of_run: expected %b, got %b",
                                 n_out, want.last, m_axis_tlast));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        n_in++;
        fold_sample(s_axis_tdata, s_axis_tlast);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        radius_reg = cfg_data_i;
        win_sum    = '0;
        n_seen     = '0;
        wr_ptr     = '0;
        n_cfg++;
      end
    end
  end

  // Stimulus sequence
  initial begin
    int unsigned        rad;
    int unsigned        wlen;
    int unsigned        len;
    int unsigned        target;
    int unsigned        smode;
    int unsigned        n_directed;
    logic               term;
    logic               lst;
    logic [SampleW-1:0] v;
    foreach (dly_line[i]) dly_line[i] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset radius: one full window with extreme samples, then a lone sample
    add_item(16'hFFFF, 1'b0);
    add_item(16'h0000, 1'b0);
    add_item(16'hFFFF, 1'b1);
    add_item(16'h5A5A, 1'b1);
    drain();

    // Radius zero: each sample is its own average
    write_radius(RadiusW'(0));
    add_item(16'hFFFF, 1'b0);
    add_item(16'h0000, 1'b0);
    add_item(16'h8001, 1'b1);
    drain();

    // Largest radius with a short stream: nothing but no-window marks
    write_radius(RadiusW'(MaxRadius));
    add_item(16'hFFFF, 1'b0);
    add_item(16'h0001, 1'b0);
    add_item(16'h0002, 1'b1);
    drain();

    // Leave a stream open, then change the radius under it
    write_radius(RadiusW'(2));
    add_item(16'd10, 1'b0);
    add_item(16'd20, 1'b0);
    add_item(16'd30, 1'b0);
    drain();
    write_radius(RadiusW'(3));

    // Radius 3: leading no-window marks, warm-up steps with no result, then averages and the flush
    for (int i = 0; i < 9; i++) add_item((i % 2 == 0) ? 16'hFFFF : 16'h0000, i == 8);
    drain();
    n_directed = n_queued;

    // Random phases: new radius, then streams of random shape and content
    while (n_queued < n_directed + RandomItems) begin
      drain();
      case ($urandom_range(0, 9))
        0:       rad = MaxRadius;
        1:       rad = $urandom_range(0, 31);
        2, 3:    rad = 0;
        default: rad = $urandom_range(1, 5);
      endcase
      if (rad == MaxRadius) n_maxr++;
      write_radius(RadiusW'(rad));
      wlen   = 2 * rad + 1;
      target = n_queued + $urandom_range(30, 70);
      while (n_queued < target) begin
        if ($urandom_range(0, 4) == 0) len = $urandom_range(1, wlen);
        else len = $urandom_range(wlen, (3 * wlen + 8 > 90) ? 90 : 3 * wlen + 8);
        smode = $urandom_range(0, 5);
        term  = ($urandom_range(0, 7) != 0);
        for (int i = 0; i < len; i++) begin
          case (smode)
            0, 1: v = SampleW'($urandom);
            2:    v = '1;
            3:    v = '0;
            4: begin
              case ($urandom_range(0, 3))
                0:       v = '0;
                1:       v = '1;
                2:       v = 16'h8000;
                default: v = 16'h7FFF;
              endcase
            end
            default: v = SampleW'($urandom_range(0, 15));
          endcase
          // occasionally cut a stream short with a stray end marker
          lst = (i == len - 1) ? term : ($urandom_range(0, 39) == 0);
          add_item(v, lst);
        end
      end
    end
    drain();

    if (exp_results.size() != 0)
      note_error($sformatf("%0d results never arrived", exp_results.size()));
    $display("Run covered %0d samples and %0d results (%0d averages, %0d no-window marks)",
             n_in, n_out, n_avg, n_none);
    $display("Radius writes: %0d, phases at the largest radius: %0d, long output stall: %s",
             n_cfg, n_maxr, did_hold ? "yes" : "no");
    if (err_count == 0) begin
      $display("centered_moving_average: match");
    end else begin
      $display("Errors: %0d", err_count);
      $display("centered_moving_average: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Timeout after %0d samples in, %0d results out", n_in, n_out);
    $display("centered_moving_average: mismatch");
    $finish;
  end

endmodule

### centered_moving_average.f
hdl/cma_pkg.sv
hdl/cma_ram.sv
hdl/cma_div.sv
hdl/cma_dp.sv
hdl/cma_ctrl.sv
hdl/centered_moving_average.sv
tb/tb_top.sv
